FILE: design/limm_pkg.sv
package limm_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_INNER = 256;
    localparam int LANES     = 4;

    localparam int LANE_W      = 8;
    localparam int WORD_W      = LANES * LANE_W;
    localparam int COL_IDX_W   = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_COLS_W  = 7;
    localparam int CFG_INNER_W = 9;
    localparam int CFG_ROWS_W  = 16;

    localparam int EFF_COLS_W  = $clog2(MAX_COLS + 1);
    localparam int EFF_INNER_W = $clog2(MAX_INNER + 1);
    localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int K_W         = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int RDEPTH      = MAX_COLS * MAX_INNER;
    localparam int RADDR_W     = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
    localparam int LIMIT_W     = $clog2(RDEPTH + 1);

    localparam logic [CFG_COLS_W-1:0]  RESET_COLS  = CFG_COLS_W'(MAX_COLS);
    localparam logic [CFG_INNER_W-1:0] RESET_INNER = CFG_INNER_W'(MAX_INNER);

    typedef logic signed [LANE_W-1:0] t_lane;
    typedef logic [LANE_W-1:0]        t_lane_u;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOUR_LANES  = 2'd0,
        CFG_RESULT_COLS = 2'd1,
        CFG_INNER_LEN   = 2'd2,
        CFG_LEFT_ROWS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CALC  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

endpackage

FILE: design/limm_ram.sv
module limm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: design/lane_interleaved_int8_matmul.sv
// Channel   Handshake                     Payload
// input     i_in_valid / o_in_ready      i_cmd, i_lane_a..i_lane_d
// result    o_out_valid / i_out_ready    o_sum_a..o_sum_d, o_column_index, o_row_end,
//                                        o_matrix_done
// config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A right-hand slot, or a left-hand slot that does not end a row, is only stored.
// A row-ending left slot starts a row computation, and input is held off until it ends: one
// 4-lane multiply-accumulate unit walks every column, one k per cycle, fed by the
// single read port of each store.
// Reset is synchronous; the stores are not cleared, positions and config are.
// A finished column waits while the result register is still held by the sink.
module lane_interleaved_int8_matmul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_cmd,
    input  limm_pkg::t_lane                     i_lane_a,
    input  limm_pkg::t_lane                     i_lane_b,
    input  limm_pkg::t_lane                     i_lane_c,
    input  limm_pkg::t_lane                     i_lane_d,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output limm_pkg::t_lane                     o_sum_a,
    output limm_pkg::t_lane                     o_sum_b,
    output limm_pkg::t_lane                     o_sum_c,
    output limm_pkg::t_lane                     o_sum_d,
    output logic [limm_pkg::COL_IDX_W-1:0]      o_column_index,
    output logic                                o_row_end,
    output logic                                o_matrix_done,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [limm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [limm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import limm_pkg::*;

    // config
    logic                   r_four_lanes;
    logic [CFG_COLS_W-1:0]  r_result_cols;
    logic [CFG_INNER_W-1:0] r_inner_len;
    logic [CFG_ROWS_W-1:0]  r_left_rows;

    logic [EFF_COLS_W-1:0]  w_cols;
    logic [EFF_INNER_W-1:0] w_inner;
    logic [CFG_ROWS_W-1:0]  w_rows;
    logic [LIMIT_W-1:0]     w_limit;

    // positions
    logic [RADDR_W-1:0]    r_wpos;
    logic [K_W-1:0]        r_left_k;
    logic [CFG_ROWS_W-1:0] r_row;
    logic [RADDR_W-1:0]    w_wpos_cur;
    logic [LIMIT_W-1:0]    w_wpos_inc;
    logic [K_W-1:0]        w_k;
    logic                  w_k_last;
    logic                  w_last_row;

    // sequencer
    t_state             r_state, n_state;
    logic [COL_W-1:0]   r_col;
    logic [RADDR_W-1:0] r_base;
    logic [K_W-1:0]     r_k;
    logic               r_last_row;
    logic               r_v1, r_v2;
    t_lane_u            r_prod [LANES];
    t_lane_u            r_acc [LANES];
    logic               w_k_end;
    logic               w_col_end;
    logic               w_load;

    // output register
    logic               r_out_valid;
    t_lane_u            r_sum [LANES];
    logic [COL_IDX_W-1:0] r_col_idx;
    logic               r_row_end, r_done;

    logic               w_in_acc;
    logic [WORD_W-1:0]  w_word;
    logic [WORD_W-1:0]  w_left_rd, w_right_rd;
    logic signed [2*LANE_W-1:0] w_mul [LANES];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_word      = {i_lane_d, i_lane_c, i_lane_b, i_lane_a};

    always_comb begin
        if (r_result_cols == '0) begin
            w_cols = EFF_COLS_W'(1);
        end else if (r_result_cols > RESET_COLS) begin
            w_cols = EFF_COLS_W'(MAX_COLS);
        end else begin
            w_cols = EFF_COLS_W'(r_result_cols);
        end
        if (r_inner_len == '0) begin
            w_inner = EFF_INNER_W'(1);
        end else if (r_inner_len > RESET_INNER) begin
            w_inner = EFF_INNER_W'(MAX_INNER);
        end else begin
            w_inner = EFF_INNER_W'(r_inner_len);
        end
        w_rows  = (r_left_rows == '0) ? CFG_ROWS_W'(1) : r_left_rows;
        w_limit = LIMIT_W'(w_cols) * LIMIT_W'(w_inner);
    end

    always_comb begin
        w_wpos_cur = (LIMIT_W'(r_wpos) < w_limit) ? r_wpos : '0;
        w_wpos_inc = LIMIT_W'(w_wpos_cur) + LIMIT_W'(1);
        w_k        = (EFF_INNER_W'(r_left_k) < w_inner) ? r_left_k
                                                        : K_W'(w_inner - EFF_INNER_W'(1));
        w_k_last   = (EFF_INNER_W'(w_k) + EFF_INNER_W'(1)) >= w_inner;
        w_last_row = ((CFG_ROWS_W + 1)'(r_row) + (CFG_ROWS_W + 1)'(1))
                     >= (CFG_ROWS_W + 1)'(w_rows);
    end

    limm_ram #(.WIDTH(WORD_W), .DEPTH(RDEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && !i_cmd),
        .i_waddr (w_wpos_cur),
        .i_wdata (w_word),
        .i_raddr (r_base + RADDR_W'(r_k)),
        .o_rdata (w_right_rd)
    );

    limm_ram #(.WIDTH(WORD_W), .DEPTH(MAX_INNER)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && i_cmd),
        .i_waddr (w_k),
        .i_wdata (w_word),
        .i_raddr (r_k),
        .o_rdata (w_left_rd)
    );

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_mul[l] = $signed(w_left_rd[l*LANE_W +: LANE_W])
                     * $signed(w_right_rd[l*LANE_W +: LANE_W]);
        end
    end

    assign w_k_end   = (EFF_INNER_W'(r_k) + EFF_INNER_W'(1)) == w_inner;
    assign w_col_end = (EFF_COLS_W'(r_col) + EFF_COLS_W'(1)) == w_cols;
    assign w_load    = (r_state == S_DRAIN) && !r_v1 && !r_v2
                       && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_cmd && w_k_last) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (w_k_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_load) begin
                    n_state = w_col_end ? S_IDLE : S_CALC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_four_lanes  <= 1'b1;
            r_result_cols <= RESET_COLS;
            r_inner_len   <= RESET_INNER;
            r_left_rows   <= CFG_ROWS_W'(1);
            r_wpos        <= '0;
            r_left_k      <= '0;
            r_row         <= '0;
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= (r_state == S_CALC);
            r_v2    <= r_v1;
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_FOUR_LANES:  r_four_lanes  <= i_cfg_data[0];
                    CFG_RESULT_COLS: r_result_cols <= i_cfg_data[CFG_COLS_W-1:0];
                    CFG_INNER_LEN:   r_inner_len   <= i_cfg_data[CFG_INNER_W-1:0];
                    CFG_LEFT_ROWS:   r_left_rows   <= i_cfg_data[CFG_ROWS_W-1:0];
                    default: ;
                endcase
            end
            if (w_in_acc && !i_cmd) begin
                r_wpos <= (w_wpos_inc >= w_limit) ? '0 : w_wpos_inc[RADDR_W-1:0];
            end
            if (w_in_acc && i_cmd) begin
                if (w_k_last) begin
                    r_left_k <= '0;
                    r_row    <= w_last_row ? '0 : r_row + CFG_ROWS_W'(1);
                end else begin
                    r_left_k <= w_k + K_W'(1);
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_cmd && w_k_last) begin
            r_last_row <= w_last_row;
            r_col      <= '0;
            r_base     <= '0;
            r_k        <= '0;
            for (int l = 0; l < LANES; l++) begin
                r_acc[l] <= '0;
            end
        end else if (r_state == S_CALC && !w_k_end) begin
            r_k <= r_k + K_W'(1);
        end else if (w_load && !w_col_end) begin
            r_col  <= r_col + COL_W'(1);
            r_base <= r_base + RADDR_W'(w_inner);
            r_k    <= '0;
            for (int l = 0; l < LANES; l++) begin
                r_acc[l] <= '0;
            end
        end
        if (r_v1) begin
            for (int l = 0; l < LANES; l++) begin
                r_prod[l] <= w_mul[l][LANE_W-1:0];
            end
        end
        if (r_v2) begin
            for (int l = 0; l < LANES; l++) begin
                r_acc[l] <= r_acc[l] + r_prod[l];
            end
        end
        if (w_load) begin
            for (int l = 0; l < LANES; l++) begin
                r_sum[l] <= (l < 2 || r_four_lanes) ? r_acc[l] : '0;
            end
            r_col_idx <= COL_IDX_W'(r_col);
            r_row_end <= w_col_end;
            r_done    <= w_col_end && r_last_row;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sum_a        = r_sum[0];
    assign o_sum_b        = r_sum[1];
    assign o_sum_c        = r_sum[2];
    assign o_sum_d        = r_sum[3];
    assign o_column_index = r_col_idx;
    assign o_row_end      = r_row_end;
    assign o_matrix_done  = r_done;

    a_done_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_matrix_done |-> o_row_end)
        else $error("matrix done without row end");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (EFF_COLS_W'(r_col) < w_cols))
        else $error("column counter out of range");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (EFF_INNER_W'(r_k) < w_inner))
        else $error("k counter out of range");

    a_pipe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_state == S_CALC || r_state == S_DRAIN))
        else $error("mac pipe active outside compute");

    a_load_empty_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !r_v1 && !r_v2 && (r_state == S_DRAIN))
        else $error("result loaded before mac pipe drained");

endmodule

FILE: tb/limm_tb_pkg.sv
`timescale 1ns / 100ps

package limm_tb_pkg;

    import limm_pkg::*;

    localparam logic SLOT_RIGHT = 1'b0;
    localparam logic SLOT_LEFT  = 1'b1;

    typedef struct packed {
        t_lane                sum_a;
        t_lane                sum_b;
        t_lane                sum_c;
        t_lane                sum_d;
        logic [COL_IDX_W-1:0] column_index;
        logic                 row_end;
        logic                 matrix_done;
    } col_result_t;

    class int8_product_board;
        bit                     four_lanes;
        bit [CFG_COLS_W-1:0]    result_cols;
        bit [CFG_INNER_W-1:0]   inner_len;
        bit [CFG_ROWS_W-1:0]    left_rows;
        logic [WORD_W-1:0]      right_words [RDEPTH];
        bit                     right_written [RDEPTH];
        logic [WORD_W-1:0]      left_words [MAX_INNER];
        int unsigned            right_pos;
        int unsigned            k_pos;
        int unsigned            row_pos;
        col_result_t            pending_columns [$];
        int                     errors;

        function new();
            four_lanes  = 1'b1;
            result_cols = RESET_COLS;
            inner_len   = RESET_INNER;
            left_rows   = 1;
            right_pos   = 0;
            k_pos       = 0;
            row_pos     = 0;
            errors      = 0;
            foreach (right_written[i]) right_written[i] = 1'b0;
        endfunction

        function int unsigned cols_used();
            if (result_cols == 0) return 1;
            if (result_cols > MAX_COLS) return MAX_COLS;
            return result_cols;
        endfunction

        function int unsigned inner_used();
            if (inner_len == 0) return 1;
            if (inner_len > MAX_INNER) return MAX_INNER;
            return inner_len;
        endfunction

        function int unsigned rows_used();
            return (left_rows == 0) ? 1 : left_rows;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FOUR_LANES:  four_lanes  = data[0];
                CFG_RESULT_COLS: result_cols = data[CFG_COLS_W-1:0];
                CFG_INNER_LEN:   inner_len   = data[CFG_INNER_W-1:0];
                CFG_LEFT_ROWS:   left_rows   = data[CFG_ROWS_W-1:0];
                default: ;
            endcase
        endfunction

        function bit slot_ends_row();
            return k_pos + 1 >= inner_used();
        endfunction

        // every right-hand entry a row end would read has been written
        function bit right_complete();
            int unsigned limit;
            limit = cols_used() * inner_used();
            for (int unsigned i = 0; i < limit; i++) begin
                if (!right_written[i]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function int lane_at(logic [WORD_W-1:0] w, int ln);
            return int'($signed(w[ln*LANE_W +: LANE_W]));
        endfunction

        function void take_slot(logic cmd, logic [WORD_W-1:0] word);
            int unsigned cols;
            int unsigned inner;
            int unsigned limit;
            int unsigned pos;
            int unsigned k;
            bit          last_row;
            int          acc [LANES];
            col_result_t res;
            cols  = cols_used();
            inner = inner_used();
            if (cmd == SLOT_RIGHT) begin
                limit = cols * inner;
                pos = (right_pos < limit) ? right_pos : 0;
                right_words[pos]   = word;
                right_written[pos] = 1'b1;
                pos++;
                right_pos = (pos >= limit) ? 0 : pos;
                return;
            end
            k = (k_pos < inner) ? k_pos : inner - 1;
            left_words[k] = word;
            if (k + 1 < inner) begin
                k_pos = k + 1;
                return;
            end
            k_pos    = 0;
            last_row = (row_pos + 1 >= rows_used());
            row_pos  = last_row ? 0 : row_pos + 1;
            for (int unsigned c = 0; c < cols; c++) begin
                foreach (acc[ln]) acc[ln] = 0;
                for (int unsigned kk = 0; kk < inner; kk++) begin
                    foreach (acc[ln]) begin
                        acc[ln] += lane_at(left_words[kk], ln) *
                                   lane_at(right_words[c*inner + kk], ln);
                    end
                end
                res.sum_a = t_lane'(acc[0]);
                res.sum_b = t_lane'(acc[1]);
                res.sum_c = four_lanes ? t_lane'(acc[2]) : '0;
                res.sum_d = four_lanes ? t_lane'(acc[3]) : '0;
                res.column_index = COL_IDX_W'(c);
                res.row_end      = (c + 1 == cols);
                res.matrix_done  = last_row && (c + 1 == cols);
                pending_columns.push_back(res);
            end
        endfunction

        function void check_field(string name, logic [LANE_W-1:0] want,
                                  logic [LANE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
                errors++;
            end
        endfunction

        function void match_column(col_result_t got);
            col_result_t want;
            if (pending_columns.size() == 0) begin
                $error("result transaction with nothing pending: column %0d",
                       got.column_index);
                errors++;
                return;
            end
            want = pending_columns.pop_front();
            check_field("sum_a", want.sum_a, got.sum_a);
            check_field("sum_b", want.sum_b, got.sum_b);
            check_field("sum_c", want.sum_c, got.sum_c);
            check_field("sum_d", want.sum_d, got.sum_d);
            check_field("column_index", LANE_W'(want.column_index), LANE_W'(got.column_index));
            check_field("row_end", LANE_W'(want.row_end), LANE_W'(got.row_end));
            check_field("matrix_done", LANE_W'(want.matrix_done), LANE_W'(got.matrix_done));
        endfunction
    endclass

endpackage

FILE: tb/lane_interleaved_int8_matmul_tb.sv
`timescale 1ns / 100ps

module lane_interleaved_int8_matmul_tb;

    import limm_pkg::*;
    import limm_tb_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int SINK_HOLD_CYCLES = 1500;
    localparam int RANDOM_ITEMS     = 180;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_cmd       = SLOT_RIGHT;
    t_lane                 i_lane_a    = '0;
    t_lane                 i_lane_b    = '0;
    t_lane                 i_lane_c    = '0;
    t_lane                 i_lane_d    = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    t_lane                 o_sum_a;
    t_lane                 o_sum_b;
    t_lane                 o_sum_c;
    t_lane                 o_sum_d;
    logic [COL_IDX_W-1:0]  o_column_index;
    logic                  o_row_end;
    logic                  o_matrix_done;
    logic                  o_cfg_ready;

    int8_product_board board = new();
    col_result_t       seen;

    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    logic        want_hold     = 1'b0;
    bit          hold_done     = 1'b0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;
    int          slots_sent    = 0;

    lane_interleaved_int8_matmul dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_lane_a       (i_lane_a),
        .i_lane_b       (i_lane_b),
        .i_lane_c       (i_lane_c),
        .i_lane_d       (i_lane_d),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_sum_a        (o_sum_a),
        .o_sum_b        (o_sum_b),
        .o_sum_c        (o_sum_c),
        .o_sum_d        (o_sum_d),
        .o_column_index (o_column_index),
        .o_row_end      (o_row_end),
        .o_matrix_done  (o_matrix_done),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result sink: random backpressure plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                seen.sum_a        = o_sum_a;
                seen.sum_b        = o_sum_b;
                seen.sum_c        = o_sum_c;
                seen.sum_d        = o_sum_d;
                seen.column_index = o_column_index;
                seen.row_end      = o_row_end;
                seen.matrix_done  = o_matrix_done;
                board.match_column(seen);
            end
            if (want_hold && !hold_done) begin
                hold_done   <= 1'b1;
                hold_left   <= SINK_HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left   <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99, 0) >= sink_idle_pct);
            end
        end
    end

    function automatic t_lane pick_lane(input bit extremes);
        t_lane corner [5];
        corner = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01};
        if (extremes) return corner[$urandom_range(4, 0)];
        return t_lane'($urandom);
    endfunction

    // a row end is never sent before its right-hand columns are all written
    task automatic send_slot(input logic cmd, input t_lane a, input t_lane b,
                             input t_lane c, input t_lane d);
        if (cmd == SLOT_LEFT && board.slot_ends_row() && !board.right_complete())
            cmd = SLOT_RIGHT;
        while ($urandom_range(99, 0) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_lane_a   <= a;
        i_lane_b   <= b;
        i_lane_c   <= c;
        i_lane_d   <= d;
        do @(posedge i_clk); while (!o_in_ready);
        board.take_slot(cmd, {d, c, b, a});
        slots_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (board.pending_columns.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input bit lanes4, input int cols, input int inner,
                             input int rows);
        logic [CFG_DATA_W-1:0] data [4];
        t_cfg_idx              idx;
        foreach (data[i]) data[i] = CFG_DATA_W'($urandom);
        data[CFG_FOUR_LANES][0]                   = lanes4;
        data[CFG_RESULT_COLS][CFG_COLS_W-1:0]     = cols[CFG_COLS_W-1:0];
        data[CFG_INNER_LEN][CFG_INNER_W-1:0]      = inner[CFG_INNER_W-1:0];
        data[CFG_LEFT_ROWS]                       = rows[CFG_ROWS_W-1:0];
        idx = CFG_FOUR_LANES;
        repeat (4) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= data[idx];
            do @(posedge i_clk); while (!o_cfg_ready);
            board.write_reg(idx, data[idx]);
            idx = idx.next();
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_stage(input bit lanes4, input int cols, input int inner,
                             input int rows, input int row_count, input int noise_pct,
                             input bit extremes);
        int unsigned fill;
        int unsigned total;
        configure(lanes4, cols, inner, rows);
        fill  = board.cols_used() * board.inner_used();
        total = fill + row_count * board.inner_used();
        for (int unsigned n = 0; n < total; n++) begin
            if ($urandom_range(99, 0) < noise_pct)
                send_slot(logic'($urandom_range(1, 0)), pick_lane(1'b0), pick_lane(1'b0),
                          pick_lane(1'b0), pick_lane(1'b0));
            send_slot((n < fill) ? SLOT_RIGHT : SLOT_LEFT, pick_lane(extremes),
                      pick_lane(extremes), pick_lane(extremes), pick_lane(extremes));
        end
        settle();
    endtask

    initial begin
        int random_start;
        int progress;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct  = 28;
        sink_idle_pct = 73;

        run_stage(1'b1, 2, 2, 2, 2, 0, 1'b1);
        // zero registers clamp to one, two-lane mode
        run_stage(1'b0, 0, 0, 0, 2, 0, 1'b1);
        run_stage(1'b1, 1, 2, 65535, 3, 0, 1'b1);
        // row position now past the smaller row count
        run_stage(1'b1, 1, 2, 2, 2, 0, 1'b1);
        // oversized column count clamps to full width
        run_stage(1'b1, 127, 1, 1, 1, 0, 1'b0);

        random_start = slots_sent;
        while (slots_sent - random_start < RANDOM_ITEMS) begin
            progress = slots_sent - random_start;
            if (progress < RANDOM_ITEMS / 3) begin
                src_idle_pct  = 28;
                sink_idle_pct = 73;
            end else if (progress < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct  = 73;
                sink_idle_pct = 28;
            end else begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (!want_hold && progress >= RANDOM_ITEMS / 2) begin
                want_hold <= 1'b1;
                run_stage(1'b1, 4, 2, 3, 5, 0, 1'b0);
            end else begin
                run_stage(1'($urandom_range(1, 0)), $urandom_range(6, 1),
                          $urandom_range(6, 1), $urandom_range(4, 0),
                          $urandom_range(3, 1), 10, $urandom_range(3, 0) == 0);
            end
        end

        if (board.errors == 0 && board.pending_columns.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
design/limm_pkg.sv
design/limm_ram.sv
design/lane_interleaved_int8_matmul.sv
tb/limm_tb_pkg.sv
tb/lane_interleaved_int8_matmul_tb.sv
